[rtl/srps_pkg.sv]
// ----------------------------------------------------------------------------
// srps_pkg
// Shared types and constants for the scaler ratio and phase-set selector.
// ----------------------------------------------------------------------------
package srps_pkg;

    // Default values for the top-level parameters.
    localparam int FRAC_BITS_DEF = 20;
    localparam int SIZE_BITS_DEF = 12;

    // Fixed field widths of the stream words.
    localparam int SIZE_FIELD_W = 12;
    localparam int FRAC_FIELD_W = 20;
    localparam int STEP_W       = 32;
    localparam int PSET_W       = 3;

    // Word widths on the two stream sides.
    localparam int IN_DATA_W  = 4 * SIZE_FIELD_W + 2 * FRAC_FIELD_W;
    localparam int OUT_DATA_W = 2 * STEP_W + 2 * PSET_W + 2;

    // Filter phase-set codes, from unity or upscale to the strongest downscale.
    localparam logic [PSET_W-1:0] PSET_UNITY = 3'd0;
    localparam logic [PSET_W-1:0] PSET_8_7   = 3'd1;
    localparam logic [PSET_W-1:0] PSET_8_6   = 3'd2;
    localparam logic [PSET_W-1:0] PSET_8_5   = 3'd3;
    localparam logic [PSET_W-1:0] PSET_8_4   = 3'd4;
    localparam logic [PSET_W-1:0] PSET_8_3   = 3'd5;
    localparam logic [PSET_W-1:0] PSET_MAX   = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new geometry word and set up both dividers
        logic step;    // one restoring-division iteration on both axes
        logic commit;  // finish the result and load the output register
    } srps_cmd_t;

endpackage

[rtl/srps_ctrl.sv]
// ----------------------------------------------------------------------------
// srps_ctrl
// Sequencer: accepts a word, runs the divider iterations, hands off the result.
// ----------------------------------------------------------------------------
module srps_ctrl
    import srps_pkg::*;
#(
    parameter int ITERS = FRAC_BITS_DEF + SIZE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output srps_cmd_t cmd
);

    localparam int CNT_W = $clog2(ITERS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             valid_reg, valid_next;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    count_next = CNT_W'(ITERS - 1);
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            ST_WAIT:
            begin
                // The output register is free, or its word leaves this cycle.
                if (!valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    assign out_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

endmodule

[rtl/srps_dp.sv]
// ----------------------------------------------------------------------------
// srps_dp
// Datapath: axis swap, two restoring dividers, phase-set binning, reload
// detection against the stored steps, and the output register.
// ----------------------------------------------------------------------------
module srps_dp
    import srps_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  srps_cmd_t               cmd,
    input  logic [IN_DATA_W-1:0]    in_data,
    input  logic                    in_swap,
    output logic [OUT_DATA_W-1:0]   out_data,
    output logic                    out_error
);

    localparam int NUM_W = SIZE_BITS + FRAC_BITS;

    // Phase-set thresholds: 8/8 .. 8/3 in FRAC_BITS fixed point.
    localparam logic [STEP_W-1:0] TH_8_8 = STEP_W'((64'd8 << FRAC_BITS) / 8);
    localparam logic [STEP_W-1:0] TH_8_7 = STEP_W'((64'd8 << FRAC_BITS) / 7);
    localparam logic [STEP_W-1:0] TH_8_6 = STEP_W'((64'd8 << FRAC_BITS) / 6);
    localparam logic [STEP_W-1:0] TH_8_5 = STEP_W'((64'd8 << FRAC_BITS) / 5);
    localparam logic [STEP_W-1:0] TH_8_4 = STEP_W'((64'd8 << FRAC_BITS) / 4);
    localparam logic [STEP_W-1:0] TH_8_3 = STEP_W'((64'd8 << FRAC_BITS) / 3);

    function automatic logic [PSET_W-1:0] bin_step(input logic [STEP_W-1:0] s);
        logic [PSET_W-1:0] p;
        if (s <= TH_8_8)      p = PSET_UNITY;
        else if (s <= TH_8_7) p = PSET_8_7;
        else if (s <= TH_8_6) p = PSET_8_6;
        else if (s <= TH_8_5) p = PSET_8_5;
        else if (s <= TH_8_4) p = PSET_8_4;
        else if (s <= TH_8_3) p = PSET_8_3;
        else                  p = PSET_MAX;
        return p;
    endfunction

    // Unpack the input word, lowest field first.
    logic [SIZE_FIELD_W-1:0] src_w, src_h, dst_w, dst_h;
    logic [FRAC_FIELD_W-1:0] frac_w, frac_h;

    assign src_w  = in_data[11:0];
    assign src_h  = in_data[23:12];
    assign frac_w = in_data[43:24];
    assign frac_h = in_data[63:44];
    assign dst_w  = in_data[75:64];
    assign dst_h  = in_data[87:76];

    // Numerator and quotient share one shift register per axis.
    logic [NUM_W-1:0]     hnum_reg, vnum_reg;
    logic [SIZE_BITS-1:0] hrem_reg, vrem_reg;
    logic [SIZE_BITS-1:0] hdst_reg, vdst_reg;
    logic [STEP_W-1:0]    last_h_reg, last_v_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_error_reg;

    logic [SIZE_BITS:0]   htrial, vtrial;
    logic                 hfit, vfit;
    logic [SIZE_BITS:0]   hdiff, vdiff;

    assign htrial = {hrem_reg, hnum_reg[NUM_W-1]};
    assign vtrial = {vrem_reg, vnum_reg[NUM_W-1]};
    assign hfit   = htrial >= {1'b0, hdst_reg};
    assign vfit   = vtrial >= {1'b0, vdst_reg};
    assign hdiff  = htrial - {1'b0, hdst_reg};
    assign vdiff  = vtrial - {1'b0, vdst_reg};

    // Final steps, with a zero destination saturating its axis.
    logic              hzero, vzero;
    logic [STEP_W-1:0] hstep, vstep;

    assign hzero = (hdst_reg == '0);
    assign vzero = (vdst_reg == '0);
    assign hstep = hzero ? '1 : STEP_W'(hnum_reg);
    assign vstep = vzero ? '1 : STEP_W'(vnum_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (in_swap)
            begin
                hnum_reg <= {src_h[SIZE_BITS-1:0], frac_h[FRAC_BITS-1:0]};
                vnum_reg <= {src_w[SIZE_BITS-1:0], frac_w[FRAC_BITS-1:0]};
            end
            else
            begin
                hnum_reg <= {src_w[SIZE_BITS-1:0], frac_w[FRAC_BITS-1:0]};
                vnum_reg <= {src_h[SIZE_BITS-1:0], frac_h[FRAC_BITS-1:0]};
            end
            hrem_reg <= '0;
            vrem_reg <= '0;
            hdst_reg <= dst_w[SIZE_BITS-1:0];
            vdst_reg <= dst_h[SIZE_BITS-1:0];
        end
        else if (cmd.step)
        begin
            hnum_reg <= {hnum_reg[NUM_W-2:0], hfit};
            vnum_reg <= {vnum_reg[NUM_W-2:0], vfit};
            hrem_reg <= hfit ? hdiff[SIZE_BITS-1:0] : htrial[SIZE_BITS-1:0];
            vrem_reg <= vfit ? vdiff[SIZE_BITS-1:0] : vtrial[SIZE_BITS-1:0];
        end
        if (cmd.commit)
        begin
            out_data_reg  <= {vstep != last_v_reg, hstep != last_h_reg,
                              bin_step(vstep), bin_step(hstep), vstep, hstep};
            out_error_reg <= hzero | vzero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_h_reg <= '0;
            last_v_reg <= '0;
        end
        else if (cmd.commit)
        begin
            last_h_reg <= hstep;
            last_v_reg <= vstep;
        end
    end

    assign out_data  = out_data_reg;
    assign out_error = out_error_reg;

endmodule

[rtl/scaler_ratio_and_phase_set_select.sv]
// ----------------------------------------------------------------------------
// scaler_ratio_and_phase_set_select
// Per-frame scale steps, filter phase sets and reload flags for a scaler.
// ----------------------------------------------------------------------------
// Sequence: an accepted input word is loaded, divided and then committed to
// the output register, which then raises m_tvalid.
// Throughput: s_tready stays low from an accepted word until its result is
// committed; the two restoring dividers retire one quotient bit per cycle per axis.
// Reset: rst_n is asynchronous and active low; it idles the sequencer, empties
// the output register and clears both stored previous steps to zero.
// ----------------------------------------------------------------------------
//
// Each input word carries one frame's geometry. With the swap flag set, the
// source sizes and fractions change axes. Each axis step is
// ((src << FRAC_BITS) + frac) / dst; a zero destination saturates the step to
// all ones and raises the error flag on tuser. The step is binned into one of
// seven filter phase sets, a threshold value falling into the lower set, and
// a reload flag marks an axis whose step differs from the previous frame.
//
// The result sits in an output register, so a new geometry word is accepted
// while the previous result still waits for the downstream side.
module scaler_ratio_and_phase_set_select
    import srps_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // Fields from bit 0: src_width[11:0], src_height[23:12], frac_width[43:24],
    // frac_height[63:44], dst_width[75:64], dst_height[87:76].
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // Fields from bit 0: swap_axes.
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // Fields from bit 0: horiz_step[31:0], vert_step[63:32],
    // horiz_phase_set[66:64], vert_phase_set[69:67], horiz_reload[70],
    // vert_reload[71].
    output logic [OUT_DATA_W-1:0] m_tdata,
    // Fields from bit 0: zero_size_error.
    output logic                  m_tuser
);

    srps_cmd_t cmd;

    // Sequencer: one load, SIZE_BITS + FRAC_BITS divide steps, one commit.
    srps_ctrl #(
        .ITERS (SIZE_BITS + FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    // Datapath: both axes divide side by side under the same commands.
    srps_dp #(
        .FRAC_BITS (FRAC_BITS),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (s_tdata),
        .in_swap   (s_tuser),
        .out_data  (m_tdata),
        .out_error (m_tuser)
    );

endmodule
